/* rtl/core/nge_pkg.sv */
// ----------------------------------------------------------------------------
// nge_pkg
// Shared types and constants of the n-body gravity Euler step block.
// ----------------------------------------------------------------------------
package nge_pkg;

   localparam int MAX_PARTICLES = 16;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAV_CONST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COUNT = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Long division: 64-bit numerator shifted left by 23
   localparam int DIV_NUM_W = 87;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   typedef struct packed {
      logic               cmd;
      logic [3:0]         slot;
      logic signed [31:0] load_px;
      logic signed [31:0] load_py;
      logic signed [31:0] load_vx;
      logic signed [31:0] load_vy;
      logic [31:0]        load_mass;
      logic [31:0]        dt;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_slot;
      logic signed [31:0] out_px;
      logic signed [31:0] out_py;
      logic signed [31:0] out_vx;
      logic signed [31:0] out_vy;
      logic               coincident;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [31:0]        mass;
   } particle_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic               hit;
   } accel_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [63:0]          denom;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
      logic [31:0] quo;
   } div_rsp_type;

endpackage

/* rtl/core/nge_isqrt.sv */
// ----------------------------------------------------------------------------
// nge_isqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module nge_isqrt
   import nge_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] bit_w;
   logic [63:0] trial;

   always_comb begin
      bit_w   = 64'(1) << {cnt_ff, 1'b0};
      trial   = res_ff + bit_w;
      rem_in  = rem_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.radicand;
         res_in  = '0;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_w;
         end else begin
            res_in = res_ff >> 1;
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = res_ff[31:0];

endmodule

/* rtl/core/nge_div.sv */
// ----------------------------------------------------------------------------
// nge_div
// Restoring long division, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
module nge_div
   import nge_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [63:0]          den_ff, den_in;
   logic [63:0]          rem_ff, rem_in;
   logic [31:0]          quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;
   logic [DIV_CNT_W-1:0] k_ff, k_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [64:0]          sh;
   logic                 ge;

   always_comb begin
      sh      = {rem_ff, num_ff[DIV_NUM_W-1]};
      ge      = (sh >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.numer;
         den_in  = req.denom;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         k_in    = DIV_CNT_W'(DIV_NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 64'(sh - {1'b0, den_ff}) : sh[63:0];
         num_in = num_ff << 1;
         quo_in = {quo_ff[30:0], ge};
         // a quotient bit at weight 2^32 or above sets the overflow flag
         if (ge && (int'(k_ff) >= 32)) begin
            ovf_in = 1'b1;
         end
         k_in = k_ff - DIV_CNT_W'(1);
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      k_ff   <= k_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.quo  = quo_ff;

endmodule

/* rtl/core/nbody_gravity_euler_step.sv */
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step
// Direct-sum 2-D gravity with a semi-implicit Euler update, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A load transaction (cmd = load) writes one particle into the state memory
// in the cycle it is accepted and leaves busy low. A step transaction first
// sums, from the old positions, the attraction on each of the first N active
// particles, then updates velocity and position of each particle in slot
// order and reports it: one rsp_valid pulse per particle, last set on the
// final one. Results come out as single-cycle strobes and cannot be held off;
// the receiver must take each one in the cycle it appears. In a step, each
// ordered pair walks through one shared 32x32 multiplier, a square root and
// three long divisions (magnitude and the two direction cosines) on one
// shared divider, which dominates the step time. A coincident pair skips
// the square root and the divisions. Each particle also passes through pair
// bookkeeping and an Euler update and write-back. Busy stays high for the
// whole step.
// ----------------------------------------------------------------------------
module nbody_gravity_euler_step
   import nge_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_RD_I, S_LAT_I, S_RD_J, S_GET_J, S_SQX, S_SQY, S_SUM,
      S_SQRT_GO, S_SQRT_WAIT, S_RR, S_GM, S_MAG_GO, S_MAG_WAIT,
      S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_CX, S_CY, S_ACY,
      S_P2_RD, S_P2_GET, S_E_M1, S_E_F1, S_E_M2, S_E_F2, S_WB
   } state_type;

   // Q16.16 product finish: drop 16 fraction bits, apply sign, saturate
   function automatic logic signed [31:0] mul_finish(input logic [63:0] prod,
                                                     input logic neg);
      logic [47:0] q;
      q = prod[63:16];
      if (!neg) begin
         mul_finish = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         mul_finish = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : -q[31:0];
      end
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         add_sat = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         add_sat = s[31:0];
      end
   endfunction

   function automatic logic signed [31:0] acc_sat(input logic signed [37:0] a);
      if (a > 38'sh0_7FFF_FFFF) begin
         acc_sat = 32'h7FFF_FFFF;
      end else if (a < -38'sh0_8000_0000) begin
         acc_sat = 32'h8000_0000;
      end else begin
         acc_sat = a[31:0];
      end
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] a);
      abs32 = a[31] ? (~a + 32'd1) : a;
   endfunction

   // Memories: particle state and per-particle acceleration
   particle_type mem [MAX_PARTICLES];
   accel_type    acc_mem [MAX_PARTICLES];

   particle_type rd_ff;
   accel_type    acc_rd_ff;
   logic         mem_we, acc_we;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   particle_type mem_wd;
   accel_type    acc_wd;

   // Control and configuration
   state_type   state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [31:0] grav_ff, grav_in, scale_ff, scale_in, dt_ff, dt_in;
   logic [4:0]  count_ff, count_in;
   logic [1:0]  ph_ff, ph_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // Pair datapath
   logic signed [31:0] pix_ff, pix_in, piy_ff, piy_in;
   logic [31:0] ux_ff, ux_in, uy_ff, uy_in, massj_ff, massj_in;
   logic        sgx_ff, sgx_in, sgy_ff, sgy_in;
   logic [63:0] sum_ff, sum_in, rr_ff, rr_in, prod_ff;
   logic [31:0] r_ff, r_in, mag_ff, mag_in, dirx_ff, dirx_in, diry_ff, diry_in;
   logic signed [37:0] accx_ff, accx_in, accy_ff, accy_in;
   logic        hit_ff, hit_in;

   // Update datapath
   particle_type cur_ff, cur_in;
   accel_type    ca_ff, ca_in;
   logic signed [31:0] t_ff, t_in;
   logic        neg_ff, neg_in;
   logic signed [31:0] nvx_ff, nvx_in, nvy_ff, nvy_in, npx_ff, npx_in, npy_ff, npy_in;

   logic [31:0] mul_a, mul_b;
   logic signed [32:0] dx, dy;
   logic [32:0] adx, ady;
   logic [37:0] term;
   logic signed [31:0] op1, base, fsum;

   sqrt_req_type sq_req;
   sqrt_rsp_type sq_rsp;
   div_req_type  dv_req;
   div_rsp_type  dv_rsp;

   nge_isqrt u_isqrt (.clock(clock), .reset(reset), .req(sq_req), .rsp(sq_rsp));
   nge_div   u_div   (.clock(clock), .reset(reset), .req(dv_req), .rsp(dv_rsp));

   always_comb begin
      // hold everything by default
      state_in = state_ff;  i_in = i_ff;  j_in = j_ff;  n_in = n_ff;
      grav_in = grav_ff;  scale_in = scale_ff;  count_in = count_ff;  dt_in = dt_ff;
      ph_in = ph_ff;  rsp_valid_in = 1'b0;  rsp_data_in = rsp_data_ff;
      pix_in = pix_ff;  piy_in = piy_ff;  ux_in = ux_ff;  uy_in = uy_ff;
      sgx_in = sgx_ff;  sgy_in = sgy_ff;  massj_in = massj_ff;
      sum_in = sum_ff;  rr_in = rr_ff;  r_in = r_ff;  mag_in = mag_ff;
      dirx_in = dirx_ff;  diry_in = diry_ff;
      accx_in = accx_ff;  accy_in = accy_ff;  hit_in = hit_ff;
      cur_in = cur_ff;  ca_in = ca_ff;  t_in = t_ff;  neg_in = neg_ff;
      nvx_in = nvx_ff;  nvy_in = nvy_ff;  npx_in = npx_ff;  npy_in = npy_ff;

      mem_we = 1'b0;  mem_wa = i_ff[IDX_W-1:0];  mem_wd = cur_ff;
      mem_ra = i_ff[IDX_W-1:0];
      acc_we = 1'b0;
      acc_wd = '{ax: acc_sat(accx_ff), ay: acc_sat(accy_ff), hit: hit_ff};
      mul_a = ux_ff;  mul_b = ux_ff;
      sq_req = '{start: 1'b0, radicand: sum_ff};
      dv_req = '{start: 1'b0, numer: {prod_ff, 23'b0}, denom: rr_ff};

      dx  = {rd_ff.px[31], rd_ff.px} - {pix_ff[31], pix_ff};
      dy  = {rd_ff.py[31], rd_ff.py} - {piy_ff[31], piy_ff};
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      ady = dy[32] ? 33'(-dy) : 33'(dy);
      term = {4'b0, prod_ff[63:30]};

      case (ph_ff)
         2'd0:    begin op1 = ca_ff.ax; base = cur_ff.vx; end
         2'd1:    begin op1 = ca_ff.ay; base = cur_ff.vy; end
         2'd2:    begin op1 = nvx_ff;   base = cur_ff.px; end
         default: begin op1 = nvy_ff;   base = cur_ff.py; end
      endcase
      fsum = add_sat(base, mul_finish(prod_ff, neg_ff));

      if (csr_we) begin
         case (csr_index)
            CSR_GRAV_CONST:   grav_in  = csr_wdata;
            CSR_SPEED_SCALE:  scale_in = csr_wdata;
            CSR_ACTIVE_COUNT: count_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.cmd == CMD_LOAD) begin
                  // drop loads beyond the store
                  if (int'(req_data.slot) < MAX_PARTICLES) begin
                     mem_we = 1'b1;
                     mem_wa = IDX_W'(req_data.slot);
                     mem_wd = '{px: req_data.load_px, py: req_data.load_py,
                                vx: req_data.load_vx, vy: req_data.load_vy,
                                mass: req_data.load_mass};
                  end
               end else begin
                  dt_in = req_data.dt;
                  n_in  = (int'(count_ff) > MAX_PARTICLES) ? CNT_W'(MAX_PARTICLES)
                                                           : CNT_W'(count_ff);
                  i_in  = '0;
                  // an empty step reports nothing
                  if (count_ff != '0) begin
                     state_in = S_RD_I;
                  end
               end
            end
         end
         S_RD_I: state_in = S_LAT_I;
         S_LAT_I: begin
            pix_in = rd_ff.px;  piy_in = rd_ff.py;
            accx_in = '0;  accy_in = '0;  hit_in = 1'b0;  j_in = '0;
            state_in = S_RD_J;
         end
         S_RD_J: begin
            if (j_ff == n_ff) begin
               // all partners seen: store the sum, advance to the next particle or, after the last, to the update pass
               acc_we = 1'b1;
               i_in = i_ff + CNT_W'(1);
               state_in = (i_ff + CNT_W'(1) == n_ff) ? S_P2_RD : S_RD_I;
               if (i_ff + CNT_W'(1) == n_ff) begin
                  i_in = '0;
               end
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               mem_ra = j_ff[IDX_W-1:0];
               j_in = j_ff + CNT_W'(1);
               state_in = S_GET_J;
            end
         end
         S_GET_J: begin
            if (dx == '0 && dy == '0) begin
               hit_in = 1'b1;
               state_in = S_RD_J;
            end else begin
               ux_in = adx[32:1];  uy_in = ady[32:1];
               sgx_in = dx[32];  sgy_in = dy[32];
               massj_in = rd_ff.mass;
               state_in = S_SQX;
            end
         end
         S_SQX: state_in = S_SQY;
         S_SQY: begin
            mul_a = uy_ff;  mul_b = uy_ff;
            sum_in = prod_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in = sum_ff + prod_ff;
            state_in = S_SQRT_GO;
         end
         S_SQRT_GO: begin
            sq_req.start = 1'b1;
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (sq_rsp.done) begin
               // a tiny but nonzero distance still divides by one
               r_in = (sq_rsp.root == '0) ? 32'd1 : sq_rsp.root;
               state_in = S_RR;
            end
         end
         S_RR: begin
            mul_a = r_ff;  mul_b = r_ff;
            state_in = S_GM;
         end
         S_GM: begin
            mul_a = grav_ff;  mul_b = massj_ff;
            rr_in = prod_ff;
            state_in = S_MAG_GO;
         end
         S_MAG_GO: begin
            dv_req.start = 1'b1;
            state_in = S_MAG_WAIT;
         end
         S_MAG_WAIT: begin
            if (dv_rsp.done) begin
               mag_in = dv_rsp.ovf ? 32'hFFFF_FFFF : dv_rsp.quo;
               state_in = S_DX_GO;
            end
         end
         S_DX_GO: begin
            dv_req = '{start: 1'b1, numer: {25'b0, ux_ff, 30'b0}, denom: {32'b0, r_ff}};
            state_in = S_DX_WAIT;
         end
         S_DX_WAIT: begin
            if (dv_rsp.done) begin
               dirx_in = dv_rsp.quo;
               state_in = S_DY_GO;
            end
         end
         S_DY_GO: begin
            dv_req = '{start: 1'b1, numer: {25'b0, uy_ff, 30'b0}, denom: {32'b0, r_ff}};
            state_in = S_DY_WAIT;
         end
         S_DY_WAIT: begin
            if (dv_rsp.done) begin
               diry_in = dv_rsp.quo;
               state_in = S_CX;
            end
         end
         S_CX: begin
            mul_a = mag_ff;  mul_b = dirx_ff;
            state_in = S_CY;
         end
         S_CY: begin
            mul_a = mag_ff;  mul_b = diry_ff;
            accx_in = sgx_ff ? accx_ff - $signed(term) : accx_ff + $signed(term);
            state_in = S_ACY;
         end
         S_ACY: begin
            accy_in = sgy_ff ? accy_ff - $signed(term) : accy_ff + $signed(term);
            state_in = S_RD_J;
         end
         S_P2_RD: state_in = S_P2_GET;
         S_P2_GET: begin
            cur_in = rd_ff;  ca_in = acc_rd_ff;  ph_in = 2'd0;
            state_in = S_E_M1;
         end
         S_E_M1: begin
            mul_a = abs32(op1);  mul_b = dt_ff;
            neg_in = op1[31];
            state_in = S_E_F1;
         end
         S_E_F1: begin
            t_in = mul_finish(prod_ff, neg_ff);
            state_in = S_E_M2;
         end
         S_E_M2: begin
            mul_a = abs32(t_ff);  mul_b = scale_ff;
            neg_in = t_ff[31];
            state_in = S_E_F2;
         end
         S_E_F2: begin
            case (ph_ff)
               2'd0:    nvx_in = fsum;
               2'd1:    nvy_in = fsum;
               2'd2:    npx_in = fsum;
               default: npy_in = fsum;
            endcase
            ph_in = ph_ff + 2'd1;
            state_in = (ph_ff == 2'd3) ? S_WB : S_E_M1;
         end
         S_WB: begin
            mem_we = 1'b1;
            mem_wd = '{px: npx_ff, py: npy_ff, vx: nvx_ff, vy: nvy_ff, mass: cur_ff.mass};
            rsp_valid_in = 1'b1;
            rsp_data_in = '{out_slot: 4'(i_ff), out_px: npx_ff, out_py: npy_ff,
                            out_vx: nvx_ff, out_vy: nvy_ff, coincident: ca_ff.hit,
                            last: (i_ff + CNT_W'(1) == n_ff)};
            i_in = i_ff + CNT_W'(1);
            state_in = (i_ff + CNT_W'(1) == n_ff) ? S_IDLE : S_P2_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and acceleration memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
      if (acc_we) begin
         acc_mem[i_ff[IDX_W-1:0]] <= acc_wd;
      end
      acc_rd_ff <= acc_mem[i_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      i_ff <= i_in;  j_ff <= j_in;  n_ff <= n_in;  dt_ff <= dt_in;  ph_ff <= ph_in;
      rsp_data_ff <= rsp_data_in;
      pix_ff <= pix_in;  piy_ff <= piy_in;  ux_ff <= ux_in;  uy_ff <= uy_in;
      sgx_ff <= sgx_in;  sgy_ff <= sgy_in;  massj_ff <= massj_in;
      sum_ff <= sum_in;  rr_ff <= rr_in;  r_ff <= r_in;  mag_ff <= mag_in;
      dirx_ff <= dirx_in;  diry_ff <= diry_in;
      accx_ff <= accx_in;  accy_ff <= accy_in;  hit_ff <= hit_in;
      cur_ff <= cur_in;  ca_ff <= ca_in;  t_ff <= t_in;  neg_ff <= neg_in;
      nvx_ff <= nvx_in;  nvy_ff <= nvy_in;  npx_ff <= npx_in;  npy_ff <= npy_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         grav_ff      <= '0;
         scale_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         grav_ff      <= grav_in;
         scale_ff     <= scale_in;
         count_ff     <= count_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a report only comes out of a running step
   a_rsp_in_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe outside a step");

   // the final report ends the step
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("block still busy after the final report");

   // a load never starts a step
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd == CMD_LOAD |=> !busy && !rsp_valid)
      else $error("load transaction made the block busy");
`endif

endmodule
